// ===== rtl/mfrp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_pkg: shared types and constants of the frame rate pacer
// Payload structs, the command passed from front to back, widths and codes.
// ----------------------------------------------------------------------------
package mfrp_pkg;

  localparam int TIME_W   = 48;
  localparam int CH_W     = 4;
  localparam int FPS_W    = 10;
  localparam int CC_W     = 5;
  localparam int ACT_W    = 2;
  localparam int PERIOD_W = 20;
  localparam int DIV_N_W  = 24;
  localparam int DIV_D_W  = 10;

  localparam int US_PER_SECOND = 1000000;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CC_W-1:0] CC_RESET = CC_W'(1);

  localparam logic [ACT_W-1:0] ACT_FRAME = 2'd0;
  localparam logic [ACT_W-1:0] ACT_QFULL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] now_us;
    logic [FPS_W-1:0]  max_fps;
  } in_t;

  typedef struct packed {
    logic              process_frame;
    logic              throttled;
    logic [TIME_W-1:0] next_due_out;
  } out_t;

  typedef enum logic [2:0] {
    KIND_FRAME,
    KIND_QFULL,
    KIND_CLEAR,
    KIND_HOLD,
    KIND_IGNORE
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [CH_W-1:0]   channel;
    logic [CH_W-1:0]   phase_rem;
    logic [CC_W-1:0]   ch_count;
    logic [FPS_W-1:0]  fps;
    logic [TIME_W-1:0] now_us;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/mfrp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_front: command intake and classification
// Holds the channel count register, clamps rate and count, computes the
// channel phase remainder and pushes a classified command into the queue.
// ----------------------------------------------------------------------------
module mfrp_front #(
  parameter int MAX_CHANNELS = mfrp_pkg::MAX_CHANNELS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  input  mfrp_pkg::in_t              cmd_i,
  input  wire                        q_full_i,
  input  wire                        cfg_valid_i,
  input  wire  [mfrp_pkg::CC_W-1:0]  cfg_data_i,
  output logic                       cfg_ready_o,
  output logic                       push_o,
  output mfrp_pkg::cmd_t             cmd_o
);

  logic [mfrp_pkg::CC_W-1:0] ch_count_q;
  logic [mfrp_pkg::CC_W-1:0] cc;
  logic [mfrp_pkg::CC_W-1:0] rem;
  logic [mfrp_pkg::CC_W-1:0] trial;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_count_q <= mfrp_pkg::CC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ch_count_q <= cfg_data_i;
    end
  end

  assign cc = (ch_count_q == '0) ? mfrp_pkg::CC_W'(1) : ch_count_q;

  // channel mod count, one restoring step per channel bit
  always_comb begin
    rem   = '0;
    trial = '0;
    for (int i = mfrp_pkg::CH_W - 1; i >= 0; i--) begin
      trial = {rem[mfrp_pkg::CC_W-2:0], cmd_i.channel[i]};
      rem   = (trial >= cc) ? trial - cc : trial;
    end
  end

  assign push_o = start && !q_full_i;

  always_comb begin
    cmd_o.channel   = cmd_i.channel;
    cmd_o.phase_rem = rem[mfrp_pkg::CH_W-1:0];
    cmd_o.ch_count  = cc;
    cmd_o.fps       = (cmd_i.max_fps == '0) ? mfrp_pkg::FPS_W'(1) : cmd_i.max_fps;
    cmd_o.now_us    = cmd_i.now_us;
    if (32'(cmd_i.channel) >= 32'(MAX_CHANNELS)) begin
      cmd_o.kind = mfrp_pkg::KIND_IGNORE;
    end else begin
      case (cmd_i.action)
        mfrp_pkg::ACT_FRAME: cmd_o.kind = mfrp_pkg::KIND_FRAME;
        mfrp_pkg::ACT_QFULL: cmd_o.kind = mfrp_pkg::KIND_QFULL;
        mfrp_pkg::ACT_CLEAR: cmd_o.kind = mfrp_pkg::KIND_CLEAR;
        default:             cmd_o.kind = mfrp_pkg::KIND_HOLD;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfrp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_queue: short command queue between front and back
// Register-based FIFO; head is visible while not empty.
// ----------------------------------------------------------------------------
module mfrp_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  mfrp_pkg::cmd_t   cmd_i,
  input  wire              pop_i,
  output logic             full_o,
  output logic             empty_o,
  output mfrp_pkg::cmd_t   head_o
);

  mfrp_pkg::cmd_t                ent_q [mfrp_pkg::QUEUE_DEPTH];
  logic [mfrp_pkg::QPTR_W-1:0]   wr_ptr_q;
  logic [mfrp_pkg::QPTR_W-1:0]   rd_ptr_q;
  logic [mfrp_pkg::QCNT_W-1:0]   cnt_q;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = (cnt_q == mfrp_pkg::QCNT_W'(mfrp_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [mfrp_pkg::QPTR_W-1:0] ptr_inc(
    input logic [mfrp_pkg::QPTR_W-1:0] p
  );
    if (p == mfrp_pkg::QPTR_W'(mfrp_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfrp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle.
// ----------------------------------------------------------------------------
module mfrp_div (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [mfrp_pkg::DIV_N_W-1:0]  dividend_i,
  input  wire  [mfrp_pkg::DIV_D_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [mfrp_pkg::DIV_N_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(mfrp_pkg::DIV_N_W);

  logic                          busy_q;
  logic                          done_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [mfrp_pkg::DIV_N_W-1:0]  quo_q;
  logic [mfrp_pkg::DIV_D_W-1:0]  rem_q;
  logic [mfrp_pkg::DIV_D_W-1:0]  dvs_q;
  logic [mfrp_pkg::DIV_D_W:0]    trial;
  logic                          ge;

  assign trial      = {rem_q, quo_q[mfrp_pkg::DIV_N_W-1]};
  assign ge         = (trial >= {1'b0, dvs_q});
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        rem_q <= ge ? mfrp_pkg::DIV_D_W'(trial - {1'b0, dvs_q})
                    : trial[mfrp_pkg::DIV_D_W-1:0];
        quo_q <= {quo_q[mfrp_pkg::DIV_N_W-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(mfrp_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mfrp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mfrp_back: per-channel due time update
// Reads the channel entry, derives period and phase with the shared divider,
// decides admit or throttle, writes the entry back and issues the result.
// ----------------------------------------------------------------------------
module mfrp_back #(
  parameter int MAX_CHANNELS = mfrp_pkg::MAX_CHANNELS_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              empty_i,
  input  mfrp_pkg::cmd_t   head_i,
  output logic             pop_o,
  output logic             result_valid_o,
  output mfrp_pkg::out_t   result_o
);

  localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TW    = mfrp_pkg::TIME_W;
  localparam int PW    = mfrp_pkg::PERIOD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PERIOD,
    S_MUL,
    S_PHASE,
    S_DECIDE
  } state_e;

  state_e                        state_q, state_d;
  mfrp_pkg::cmd_t                cmd_q, cmd_d;
  logic [TW-1:0]                 due_q, due_d;
  logic [PW-1:0]                 period_q, period_d;
  logic [mfrp_pkg::DIV_N_W-1:0]  prod_q, prod_d;
  logic                          res_valid_q, res_valid_d;
  mfrp_pkg::out_t                res_q, res_d;

  logic [TW-1:0]                 mem_q [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0]       vld_q;
  logic [TW-1:0]                 rd_data_q;
  logic                          rd_vld_q;

  logic                          wr_en;
  logic [TW-1:0]                 wr_data;
  logic [IDX_W-1:0]              wr_idx;
  logic [IDX_W-1:0]              head_idx;
  logic [TW-1:0]                 entry;

  logic                          div_start;
  logic                          div_done;
  logic [mfrp_pkg::DIV_N_W-1:0]  div_a;
  logic [mfrp_pkg::DIV_D_W-1:0]  div_b;
  logic [mfrp_pkg::DIV_N_W-1:0]  div_q;

  logic [TW+1:0]                 lag_lim;
  logic [TW-1:0]                 half_next;
  logic [TW-1:0]                 step_next;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                            input logic [TW-1:0] b);
    logic [TW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TW] ? {TW{1'b1}} : s[TW-1:0];
  endfunction

  mfrp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  assign head_idx = IDX_W'(head_i.channel);
  assign wr_idx   = IDX_W'(cmd_q.channel);
  assign entry    = rd_vld_q ? rd_data_q : '0;

  assign div_a = (state_q == S_MUL) ? prod_q
                                    : mfrp_pkg::DIV_N_W'(mfrp_pkg::US_PER_SECOND);
  assign div_b = (state_q == S_MUL) ? mfrp_pkg::DIV_D_W'(cmd_q.ch_count) : cmd_q.fps;

  assign lag_lim   = {2'b00, due_q} + (TW+2)'({period_q, 1'b0});
  assign half_next = sat_add(cmd_q.now_us, TW'(period_q[PW-1:1]));
  assign step_next = sat_add(due_q, TW'(period_q));

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    due_d       = due_q;
    period_d    = period_q;
    prod_d      = prod_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop_o       = 1'b0;
    div_start   = 1'b0;
    wr_en       = 1'b0;
    wr_data     = '0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = head_i;
          state_d = S_READ;
        end
      end
      S_READ: begin
        res_d = '0;
        case (cmd_q.kind)
          mfrp_pkg::KIND_FRAME, mfrp_pkg::KIND_QFULL: begin
            div_start = 1'b1;
            due_d     = entry;
            state_d   = S_PERIOD;
          end
          mfrp_pkg::KIND_CLEAR: begin
            wr_en       = 1'b1;
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
          mfrp_pkg::KIND_HOLD: begin
            res_d.next_due_out = entry;
            res_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end
          default: begin
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end
        endcase
      end
      S_PERIOD: begin
        if (div_done) begin
          period_d = div_q[PW-1:0];
          prod_d   = mfrp_pkg::DIV_N_W'(div_q[PW-1:0]) *
                     mfrp_pkg::DIV_N_W'(cmd_q.phase_rem);
          if (cmd_q.kind == mfrp_pkg::KIND_QFULL) begin
            wr_en              = 1'b1;
            wr_data            = sat_add(cmd_q.now_us, TW'(div_q[PW-1:1]));
            res_d              = '0;
            res_d.next_due_out = wr_data;
            res_valid_d        = 1'b1;
            state_d            = S_IDLE;
          end else if (due_q != '0) begin
            state_d = S_DECIDE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_d   = S_PHASE;
      end
      S_PHASE: begin
        if (div_done) begin
          due_d   = sat_add(cmd_q.now_us, TW'(div_q));
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_d = '0;
        if (cmd_q.now_us < due_q) begin
          wr_data         = due_q;
          res_d.throttled = 1'b1;
        end else begin
          wr_data             = ({2'b00, cmd_q.now_us} > lag_lim) ? half_next : step_next;
          res_d.process_frame = 1'b1;
        end
        wr_en              = 1'b1;
        res_d.next_due_out = wr_data;
        res_valid_d        = 1'b1;
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      due_q       <= '0;
      period_q    <= '0;
      prod_q      <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      due_q       <= due_d;
      period_q    <= period_d;
      prod_q      <= prod_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
    end
  end

  // entry store; a read and a write never fall in the same cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rd_data_q <= mem_q[head_idx];
    end
    if (wr_en) begin
      mem_q[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        rd_vld_q <= vld_q[head_idx];
      end
      if (wr_en) begin
        vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule
`default_nettype wire

// ===== rtl/multichannel_frame_rate_pacer_top.sv =====
// Channel reset, unused action codes and out-of-range channels are answered
// without the iterative divider. Queue full takes the period division; a frame
// on a set channel takes the period division and then the decision; a channel's
// first frame divides for the period, then for the stagger phase, and decides.
// One event is worked at a time, and a 2-entry queue takes new transfers.
// After reset all channels are unset and channel_count is 1; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_frame_rate_pacer_top: phase-staggered frame rate limiter
// Front classifies events, a short queue decouples it from the back end,
// which keeps the per-channel due times and produces one result per event.
// ----------------------------------------------------------------------------
module multichannel_frame_rate_pacer_top #(
  parameter int MAX_CHANNELS = mfrp_pkg::MAX_CHANNELS_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        start,
  output logic                       busy,
  input  mfrp_pkg::in_t              cmd_i,
  output logic                       result_valid_o,
  output mfrp_pkg::out_t             result_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [mfrp_pkg::CC_W-1:0]  cfg_data_i
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  mfrp_pkg::cmd_t  front_cmd;
  mfrp_pkg::cmd_t  head_cmd;

  assign busy = q_full;

  mfrp_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .q_full_i    (q_full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  mfrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .head_o  (head_cmd)
  );

  mfrp_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .head_i         (head_cmd),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire
